// ===== src/sorted_set_cosine_similarity_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef SORTED_SET_COSINE_SIMILARITY_MACROS_SVH
`define SORTED_SET_COSINE_SIMILARITY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sscs check failed");

// Next-cycle implication, disabled during reset.
`define SSCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sscs check failed");

`endif

// ===== src/sscs_pkg.sv =====
package sscs_pkg;

  localparam int INDEX_W    = 32;
  localparam int MODE_W     = 2;
  localparam int MATCH_W    = 11;
  localparam int SIM_W      = 17;
  localparam int FRAC_W     = 32;            // c*c is scaled by 2^32
  localparam int QUOT_W     = 33;            // quotient never exceeds 2^32
  localparam int ROOT_STEPS = 17;            // one root bit per step
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int SREM_W     = ROOT_STEPS + 3;

  localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  typedef struct packed {
    logic load;        // input beat accepted
    logic walk_step;   // compare heads, advance pointers
    logic mul;         // form c*c and n1*n2
    logic div_step;    // one quotient bit
    logic sqrt_init;   // load radicand
    logic sqrt_step;   // one root bit
    logic out_load;    // capture result, clear counts
  } sscs_cmd_t;

  typedef struct packed {
    logic more;        // both lists still have elements
    logic empty;       // either list holds nothing
  } sscs_status_t;

endpackage

// ===== src/sorted_set_cosine_similarity.sv =====
// Channel   Dir  Fields (tdata / tuser, lowest bit first)
// s_axis    in   tdata: item_index[31:0]; tuser: mode[1:0]
// m_axis    out  tdata: match_count[10:0], similarity[27:11], zero pad;
//                tuser: empty_flag[0], overflow_flag[1]
//
// A load (mode 0 or 1) or an unused mode is accepted from idle. A finish
// runs accept, the merge walk (read, compare; steps <= n1+n2), multiply,
// 2*ceil(log2(LIST_DEPTH+1))+32 divide steps (54 by default), square-root
// load, 17 root steps and output load; an empty list skips to the output
// load. Input is held off for the whole finish, including any wait for the
// output register to drain. Synchronous reset clears state and counts.
`include "sorted_set_cosine_similarity_macros.svh"

module sorted_set_cosine_similarity #(
  parameter int LIST_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_index[31:0]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // match_count[10:0], similarity[27:11], pad[31:28]
  output logic [1:0]  m_tuser    // empty_flag[0], overflow_flag[1]
);
  import sscs_pkg::*;

  sscs_cmd_t    cmd;
  sscs_status_t status;

  logic [MATCH_W-1:0] match_count;
  logic [SIM_W-1:0]   similarity;
  logic               empty_flag;
  logic               overflow_flag;

  sscs_ctrl #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sscs_datapath #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (s_tuser),
    .item_index    (s_tdata),
    .match_count   (match_count),
    .similarity    (similarity),
    .empty_flag    (empty_flag),
    .overflow_flag (overflow_flag)
  );

  assign m_tdata = {4'b0000, similarity, match_count};
  assign m_tuser = {overflow_flag, empty_flag};

  `SSCS_ASSERT_NOW(a_empty_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata[27:0] == 28'd0)
  `SSCS_ASSERT_NOW(a_sim_range, clk, rst, m_tvalid && m_tdata[27], m_tdata[26:11] == 16'd0)
  `SSCS_ASSERT_NEXT(a_finish_busy, clk, rst, s_tvalid && s_tready && s_tuser == MODE_FINISH, !s_tready)

endmodule

// ===== src/sscs_ctrl.sv =====
module sscs_ctrl #(
  parameter int LIST_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sscs_pkg::MODE_W-1:0] mode,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  sscs_pkg::sscs_status_t      status,
  output sscs_pkg::sscs_cmd_t         cmd
);
  import sscs_pkg::*;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int DIV_N  = 2 * CNT_W + FRAC_W;
  localparam int ITER_W = $clog2(DIV_N);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRD   = 3'd1;
  localparam logic [2:0] ST_WCMP  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SINIT = 3'd5;
  localparam logic [2:0] ST_SQRT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid && mode == MODE_FINISH) state_next = ST_WRD;
      end
      ST_WRD: begin
        // read data for the current pointers lands at the next edge
        if (status.more) state_next = ST_WCMP;
        else if (status.empty) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_WCMP: begin
        cmd.walk_step = 1'b1;
        state_next = ST_WRD;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        iter_next = ITER_W'(DIV_N - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == '0) state_next = ST_SINIT;
        else iter_next = iter - 1'b1;
      end
      ST_SINIT: begin
        cmd.sqrt_init = 1'b1;
        iter_next = ITER_W'(ROOT_STEPS - 1);
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter == '0) state_next = ST_DONE;
        else iter_next = iter - 1'b1;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      iter     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== src/sscs_datapath.sv =====
module sscs_datapath #(
  parameter int LIST_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sscs_pkg::sscs_cmd_t           cmd,
  output sscs_pkg::sscs_status_t        status,
  input  logic [sscs_pkg::MODE_W-1:0]   mode,
  input  logic [sscs_pkg::INDEX_W-1:0]  item_index,
  output logic [sscs_pkg::MATCH_W-1:0]  match_count,
  output logic [sscs_pkg::SIM_W-1:0]    similarity,
  output logic                          empty_flag,
  output logic                          overflow_flag
);
  import sscs_pkg::*;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int PROD_W = 2 * CNT_W;
  localparam int X_W    = PROD_W + FRAC_W;

  logic [INDEX_W-1:0] list_a [LIST_DEPTH];
  logic [INDEX_W-1:0] list_b [LIST_DEPTH];
  logic signed [INDEX_W-1:0] head_a, head_b;

  logic [CNT_W-1:0] n1, n2, pa, pb, hits;
  logic             dropped;
  logic             wr_a, wr_b, full_a, full_b;

  logic [X_W-1:0]    dvd;
  logic [PROD_W-1:0] dvs, rem;
  logic [PROD_W:0]   rem_sh, rem_diff;
  logic [QUOT_W-1:0] quot;
  logic [PROD_W-1:0] cc_full, pp_full;

  logic [RAD_W-1:0]      rad;
  logic [SREM_W-1:0]     srem, srem_sh, trial;
  logic [ROOT_STEPS-1:0] root;

  assign full_a = (n1 == CNT_W'(LIST_DEPTH));
  assign full_b = (n2 == CNT_W'(LIST_DEPTH));
  assign wr_a   = cmd.load && mode == MODE_LOAD_A && !full_a;
  assign wr_b   = cmd.load && mode == MODE_LOAD_B && !full_b;

  assign status.more  = (pa < n1) && (pb < n2);
  assign status.empty = (n1 == '0) || (n2 == '0);

  // list storage: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_a) list_a[n1[ADDR_W-1:0]] <= item_index;
    head_a <= list_a[pa[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) list_b[n2[ADDR_W-1:0]] <= item_index;
    head_b <= list_b[pb[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      n1      <= '0;
      n2      <= '0;
      dropped <= 1'b0;
      pa      <= '0;
      pb      <= '0;
      hits    <= '0;
    end else begin
      if (wr_a) n1 <= n1 + 1'b1;
      if (wr_b) n2 <= n2 + 1'b1;
      if (cmd.load && ((mode == MODE_LOAD_A && full_a) || (mode == MODE_LOAD_B && full_b)))
        dropped <= 1'b1;
      if (cmd.walk_step) begin
        if (head_a == head_b) begin
          hits <= hits + 1'b1;
          pa <= pa + 1'b1;
          pb <= pb + 1'b1;
        end else if (head_a > head_b) begin
          pb <= pb + 1'b1;
        end else begin
          pa <= pa + 1'b1;
        end
      end
    end
  end

  // restoring division of c*c*2^32 by n1*n2, one quotient bit per cycle
  assign cc_full  = PROD_W'(hits) * PROD_W'(hits);
  assign pp_full  = PROD_W'(n1) * PROD_W'(n2);
  assign rem_sh   = {rem, dvd[X_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      dvd  <= {cc_full, {FRAC_W{1'b0}}};
      dvs  <= pp_full;
      rem  <= '0;
      quot <= '0;
    end else if (cmd.div_step) begin
      dvd <= {dvd[X_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs}) begin
        rem  <= rem_diff[PROD_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[PROD_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
  end

  // digit-by-digit integer square root of the quotient
  assign srem_sh = {srem[SREM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad  <= RAD_W'(quot);
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem <= srem_sh - trial;
        root <= {root[ROOT_STEPS-2:0], 1'b1};
      end else begin
        srem <= srem_sh;
        root <= {root[ROOT_STEPS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      match_count   <= MATCH_W'(hits);
      similarity    <= status.empty ? '0 : SIM_W'(root);
      empty_flag    <= status.empty;
      overflow_flag <= dropped;
    end
  end

endmodule

// ===== dv/sorted_set_cosine_similarity_test.sv =====
`timescale 1ns / 100ps

module sorted_set_cosine_similarity_test;
  import sscs_pkg::*;

  localparam int LIST_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 300;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MATCH_W-1:0] hits;
    logic [SIM_W-1:0]   cosine;
    logic               empty;
    logic               dropped;
  } score_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  // model of the block's list storage
  int          held_a[LIST_DEPTH];
  int          held_b[LIST_DEPTH];
  int unsigned len_a = 0;
  int unsigned len_b = 0;
  bit          drop_pending = 1'b0;
  score_t      pending_scores[$];

  int          stage_a[$];
  int          stage_b[$];
  int          sent_items = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sink_hold_req = 0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;

  sorted_set_cosine_similarity #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_set_cosine_similarity_test: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap(input bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // largest r with r*r*n1*n2 <= c*c*2^32
  function automatic logic [SIM_W-1:0] floor_cosine_q16(input int unsigned n1,
                                                        input int unsigned n2,
                                                        input int unsigned c);
    logic [63:0] prod, target, lo, hi, mid;
    prod   = 64'(n1) * 64'(n2);
    target = (64'(c) * 64'(c)) << FRAC_W;
    lo     = 64'd0;
    hi     = 64'd65536;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (mid * mid * prod <= target) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo[SIM_W-1:0];
  endfunction

  task automatic absorb_beat(input logic [MODE_W-1:0] mode, input logic [31:0] index);
    int unsigned i, j, c;
    score_t      score;
    i = 0;
    j = 0;
    c = 0;
    case (mode)
      MODE_LOAD_A: begin
        if (len_a < LIST_DEPTH) begin
          held_a[len_a] = index;
          len_a++;
        end else drop_pending = 1'b1;
      end
      MODE_LOAD_B: begin
        if (len_b < LIST_DEPTH) begin
          held_b[len_b] = index;
          len_b++;
        end else drop_pending = 1'b1;
      end
      MODE_FINISH: begin
        while (i < len_a && j < len_b) begin
          if (held_a[i] == held_b[j]) begin
            c++;
            i++;
            j++;
          end else if (held_a[i] > held_b[j]) j++;
          else i++;
        end
        score.hits    = c[MATCH_W-1:0];
        score.empty   = (len_a == 0 || len_b == 0);
        score.cosine  = score.empty ? '0 : floor_cosine_q16(len_a, len_b, c);
        score.dropped = drop_pending;
        pending_scores.push_back(score);
        len_a = 0;
        len_b = 0;
        drop_pending = 1'b0;
      end
      default: ;
    endcase
  endtask

  // entered and left just after a rising edge
  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [31:0] index);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= index;
    s_tuser  <= mode;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    absorb_beat(mode, index);
    if (mode != MODE_UNUSED) sent_items++;
  endtask

  // interleave the staged lists, with an occasional unused-mode beat, then finish
  task automatic send_staged();
    int ia, ib;
    ia = 0;
    ib = 0;
    while (ia < stage_a.size() || ib < stage_b.size()) begin
      if (ib >= stage_b.size() || (ia < stage_a.size() && $urandom_range(0, 1) == 0)) begin
        send_beat(MODE_LOAD_A, stage_a[ia]);
        ia++;
      end else begin
        send_beat(MODE_LOAD_B, stage_b[ib]);
        ib++;
      end
      if ($urandom_range(0, 49) == 0) send_beat(MODE_UNUSED, $urandom);
    end
    send_beat(MODE_FINISH, $urandom);
    stage_a.delete();
    stage_b.delete();
  endtask

  // ascending values spread over the signed range, shared out between lists
  task automatic stage_random_sets();
    int     k, roll, p, q, tmp;
    longint step_max, slack, v;
    k = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
    case ($urandom_range(0, 2))
      0: step_max = 3;
      1: step_max = 2000;
      default: step_max = longint'(64'hFFFF_FFFF) / (k + 1);
    endcase
    slack = longint'(64'hFFFF_FFFF) - k * step_max;
    v = longint'(int'(32'h8000_0000)) + (longint'($urandom) % (slack + 1));
    for (int n = 0; n < k; n++) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        stage_a.push_back(int'(v));
        stage_b.push_back(int'(v));
      end else if (roll < 7) stage_a.push_back(int'(v));
      else stage_b.push_back(int'(v));
      v += $urandom_range(1, int'(step_max));
    end
    // break the ordering now and then
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 2))
        0: begin
          if (stage_a.size() >= 2) begin
            p = $urandom_range(0, stage_a.size() - 1);
            q = $urandom_range(0, stage_a.size() - 1);
            tmp = stage_a[p];
            stage_a[p] = stage_a[q];
            stage_a[q] = tmp;
          end
        end
        1: stage_b.push_front($urandom);
        default: begin
          if (stage_b.size() > 0) stage_b.push_back(stage_b[stage_b.size() - 1]);
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50)
      $display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // result is settled by the falling edge and taken at the next rising one
  always @(negedge clk) begin
    score_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_scores.size() == 0) begin
        report_mismatch("unrequested result", m_tdata, 32'd0);
      end else begin
        want = pending_scores.pop_front();
        if (m_tdata[10:0] !== want.hits)
          report_mismatch("match_count", 32'(m_tdata[10:0]), 32'(want.hits));
        if (m_tdata[27:11] !== want.cosine)
          report_mismatch("similarity", 32'(m_tdata[27:11]), 32'(want.cosine));
        if (m_tuser[0] !== want.empty)
          report_mismatch("empty_flag", 32'(m_tuser[0]), 32'(want.empty));
        if (m_tuser[1] !== want.dropped)
          report_mismatch("overflow_flag", 32'(m_tuser[1]), 32'(want.dropped));
      end
    end
  end

  initial begin : sink_drive
    int hold;
    forever begin
      @(posedge clk);
      if (sink_hold_req > 0) begin
        hold = sink_hold_req;
        sink_hold_req = 0;
        m_tready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
      end else begin
        hold = pick_gap(sink_steady);
        if (hold == 0) m_tready <= 1'b1;
        else begin
          m_tready <= 1'b0;
          repeat (hold - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic test_empty_lists();
    send_beat(MODE_FINISH, 32'h0);
    stage_a.push_back(7);
    send_staged();
    stage_b.push_back(-3);
    send_staged();
    send_beat(MODE_UNUSED, 32'hFFFF_FFFF);
    send_beat(MODE_FINISH, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_lists();
    stage_a = '{int'(32'h8000_0000), -1, 0, int'(32'h7FFF_FFFF)};
    stage_b = '{int'(32'h8000_0000), 0, 1, int'(32'h7FFF_FFFF)};
    send_staged();
    stage_a = '{int'(32'h7FFF_FFFF)};
    stage_b = '{int'(32'h7FFF_FFFF)};
    send_staged();
    stage_a = '{1, 2};
    stage_b = '{3, 4};
    send_staged();
    // out of order: the walk skips what a sorted walk would match
    stage_a = '{9, 2, 5};
    stage_b = '{2, 5, 9};
    send_staged();
  endtask

  // one more element than fits in the first list, a sparse subset in the second
  task automatic test_full_lists();
    longint base;
    base = longint'(int'(32'h8000_0000)) + $urandom_range(0, 4194303);
    for (int n = 0; n <= LIST_DEPTH; n++) begin
      stage_a.push_back(int'(base + n * 64'd4194304));
      if (n % 97 == 0) stage_b.push_back(int'(base + n * 64'd4194304));
    end
    send_staged();
    stage_a.push_back(11);
    stage_b.push_back(11);
    send_staged();
  endtask

  // hold the sink long enough for the block to stall its input
  task automatic test_sink_stall();
    src_steady = 1'b1;
    sink_hold_req = 600;
    repeat (4) begin
      stage_random_sets();
      send_staged();
    end
    src_steady = 1'b0;
  endtask

  task automatic test_random_sets();
    int start;
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      src_steady  = ($urandom_range(0, 4) == 0);
      sink_steady = ($urandom_range(0, 4) == 0);
      stage_random_sets();
      send_staged();
    end
    sink_steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_lists();
    test_directed_lists();
    test_full_lists();
    test_sink_stall();
    test_random_sets();
    s_tvalid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_scores.size() == 0)
      $display("sorted_set_cosine_similarity_test: done, clean");
    else
      $display("sorted_set_cosine_similarity_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sscs_pkg.sv
src/sscs_ctrl.sv
src/sscs_datapath.sv
src/sorted_set_cosine_similarity.sv
dv/sorted_set_cosine_similarity_test.sv
